// ===== rtl/krt_pkg.sv =====
package krt_pkg;

    localparam int RECORD_BITS = 8;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int MAP_BITS    = RECORD_BITS + 1;
    localparam int REC_LIMIT   = 1 << RECORD_BITS;
    localparam int MAP_SIZE    = 1 << MAP_BITS;
    localparam int COUNT_BITS  = RECORD_BITS + 1;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_PUT    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INSERTED = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_PR_RD,
        S_PR_CHK,
        S_PR_KEY,
        S_LK_VAL,
        S_D_RDL,
        S_D_MOV,
        S_RP_RD,
        S_RP_CHK,
        S_SH_RD,
        S_SH_CHK,
        S_SH_KEY
    } state_t;

    typedef struct packed {
        logic                   used;
        logic [RECORD_BITS-1:0] slot;
    } map_ent_t;

    typedef struct packed {
        logic                eq;
        logic                movable;
        logic [MAP_BITS-1:0] pos_inc;
    } step_res_t;

    function automatic logic [MAP_BITS-1:0] home_of(input logic [KEY_WIDTH-1:0] k);
        return k[MAP_BITS-1:0];
    endfunction

endpackage

// ===== rtl/krt_ram.sv =====
module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/krt_step.sv =====
// Shared probe step: key compare, cursor advance, shift-eligibility test.
module krt_step (
    input  logic [krt_pkg::KEY_WIDTH-1:0] key_a,
    input  logic [krt_pkg::KEY_WIDTH-1:0] key_b,
    input  logic [krt_pkg::MAP_BITS-1:0]  pos,
    input  logic [krt_pkg::MAP_BITS-1:0]  hole,
    output krt_pkg::step_res_t            res
);

    logic [krt_pkg::MAP_BITS-1:0] h;

    always_comb
    begin
        h           = krt_pkg::home_of(key_b);
        res.eq      = (key_a == key_b);
        res.pos_inc = pos + 1'b1;
        if (pos > hole)
        begin
            res.movable = (h <= hole) || (h > pos);
        end
        else
        begin
            res.movable = (h <= hole) && (h > pos);
        end
    end

endmodule

// ===== rtl/keyed_record_table_linear_probe.sv =====
// Keyed record table with a linear-probing index map (2x record capacity)
// and backward-shift delete. Issue a command with start while busy is low;
// done pulses for exactly one cycle with status, read_value and record_total
// and cannot be held off. One command at a time: each visited map entry
// takes a map read, a key read and a compare through one shared step unit.
// Delete then moves the last record into the freed slot (unless the freed
// slot was the last), walks the map to repoint that record's entry, and
// shifts the cluster back entry by entry. After reset the map is swept
// empty with busy high; default_value writes are taken at any time
// (cfg_ready is tied high) but should be made only while idle.
module keyed_record_table_linear_probe (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      cmd,
    input  logic [krt_pkg::KEY_WIDTH-1:0]   key,
    input  logic [krt_pkg::VALUE_WIDTH-1:0] value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [31:0]                     cfg_data,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [31:0]                     read_value,
    output logic [krt_pkg::COUNT_BITS-1:0]  record_total
);

    localparam int RB = krt_pkg::RECORD_BITS;
    localparam int MB = krt_pkg::MAP_BITS;
    localparam int EW = $bits(krt_pkg::map_ent_t);

    krt_pkg::state_t state_reg, state_next;
    logic [1:0]     cmd_reg, cmd_next;
    logic [krt_pkg::KEY_WIDTH-1:0]   key_reg, key_next;
    logic [krt_pkg::VALUE_WIDTH-1:0] value_reg, value_next;
    logic [MB-1:0]  pos_reg, pos_next;
    logic [MB-1:0]  hole_reg, hole_next;
    logic [RB-1:0]  slot_reg, slot_next;
    krt_pkg::map_ent_t ent_reg, ent_next;
    logic [krt_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [31:0]    dflt_reg;
    logic           done_reg, done_next;
    logic [1:0]     status_reg, status_next;
    logic [31:0]    rdv_reg, rdv_next;

    // memory ports
    logic          map_we, key_we, val_we;
    logic [MB-1:0] map_waddr, map_raddr;
    logic [RB-1:0] key_waddr, key_raddr, val_waddr, val_raddr;
    krt_pkg::map_ent_t map_wdata, map_rd;
    logic [EW-1:0] map_rdata;
    logic [krt_pkg::KEY_WIDTH-1:0]   key_wdata, key_rdata;
    logic [krt_pkg::VALUE_WIDTH-1:0] val_wdata, val_rdata;

    krt_pkg::step_res_t step;

    krt_ram #(.WIDTH(EW), .DEPTH(krt_pkg::MAP_SIZE)) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    krt_ram #(.WIDTH(krt_pkg::KEY_WIDTH), .DEPTH(krt_pkg::REC_LIMIT)) u_keys (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    krt_ram #(.WIDTH(krt_pkg::VALUE_WIDTH), .DEPTH(krt_pkg::REC_LIMIT)) u_vals (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    assign map_rd = krt_pkg::map_ent_t'(map_rdata);

    // One step unit serves probe compare, repoint walk and cluster shift
    krt_step u_step (
        .key_a(key_reg),
        .key_b(key_rdata),
        .pos  (pos_reg),
        .hole (hole_reg),
        .res  (step)
    );

    assign busy         = (state_reg != krt_pkg::S_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign status       = status_reg;
    assign read_value   = rdv_reg;
    assign record_total = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= krt_pkg::S_CLR;
            pos_reg    <= '0;
            count_reg  <= '0;
            dflt_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                dflt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        hole_reg   <= hole_next;
        slot_reg   <= slot_next;
        ent_reg    <= ent_next;
        status_reg <= status_next;
        rdv_reg    <= rdv_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        hole_next   = hole_reg;
        slot_next   = slot_reg;
        ent_next    = ent_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rdv_next    = rdv_reg;

        map_we    = 1'b0;
        map_waddr = pos_reg;
        map_wdata = '0;
        map_raddr = pos_reg;
        key_we    = 1'b0;
        key_waddr = count_reg[RB-1:0];
        key_wdata = key_reg;
        key_raddr = map_rd.slot;
        val_we    = 1'b0;
        val_waddr = count_reg[RB-1:0];
        val_wdata = value_reg;
        val_raddr = slot_reg;

        unique case (state_reg)
            krt_pkg::S_CLR:
            begin
                map_we    = 1'b1;
                map_waddr = pos_reg;
                pos_next  = pos_reg + 1'b1;
                if (pos_reg == MB'(krt_pkg::MAP_SIZE - 1))
                begin
                    state_next = krt_pkg::S_IDLE;
                end
            end

            krt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    key_next   = key;
                    value_next = value;
                    pos_next   = krt_pkg::home_of(key);
                    if (cmd == krt_pkg::CMD_NONE)
                    begin
                        done_next   = 1'b1;
                        status_next = krt_pkg::ST_MISSING;
                        rdv_next    = '0;
                    end
                    else
                    begin
                        state_next = krt_pkg::S_PR_RD;
                    end
                end
            end

            krt_pkg::S_PR_RD:
            begin
                map_raddr  = pos_reg;
                state_next = krt_pkg::S_PR_CHK;
            end

            krt_pkg::S_PR_CHK:
            begin
                if (!map_rd.used)
                begin
                    // key absent; pos_reg is the first free entry
                    state_next  = krt_pkg::S_IDLE;
                    done_next   = 1'b1;
                    rdv_next    = '0;
                    status_next = krt_pkg::ST_MISSING;
                    if (cmd_reg == krt_pkg::CMD_LOOKUP)
                    begin
                        rdv_next = dflt_reg;
                    end
                    else if (cmd_reg == krt_pkg::CMD_PUT)
                    begin
                        if (count_reg[RB])
                        begin
                            status_next = krt_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next = krt_pkg::ST_INSERTED;
                            key_we      = 1'b1;
                            val_we      = 1'b1;
                            map_we      = 1'b1;
                            map_waddr   = pos_reg;
                            map_wdata   = '{used: 1'b1, slot: count_reg[RB-1:0]};
                            count_next  = count_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    key_raddr  = map_rd.slot;
                    slot_next  = map_rd.slot;
                    state_next = krt_pkg::S_PR_KEY;
                end
            end

            krt_pkg::S_PR_KEY:
            begin
                if (!step.eq)
                begin
                    pos_next   = step.pos_inc;
                    state_next = krt_pkg::S_PR_RD;
                end
                else
                begin
                    unique case (cmd_reg)
                        krt_pkg::CMD_LOOKUP:
                        begin
                            val_raddr  = slot_reg;
                            state_next = krt_pkg::S_LK_VAL;
                        end
                        krt_pkg::CMD_PUT:
                        begin
                            val_we      = 1'b1;
                            val_waddr   = slot_reg;
                            done_next   = 1'b1;
                            status_next = krt_pkg::ST_OK;
                            rdv_next    = '0;
                            state_next  = krt_pkg::S_IDLE;
                        end
                        default:
                        begin
                            // delete: hole opens at the hit entry
                            count_next = count_reg - 1'b1;
                            hole_next  = pos_reg;
                            if ({1'b0, slot_reg} < count_next)
                            begin
                                state_next = krt_pkg::S_D_RDL;
                            end
                            else
                            begin
                                pos_next   = pos_reg + 1'b1;
                                state_next = krt_pkg::S_SH_RD;
                            end
                        end
                    endcase
                end
            end

            krt_pkg::S_LK_VAL:
            begin
                done_next   = 1'b1;
                status_next = krt_pkg::ST_OK;
                rdv_next    = val_rdata;
                state_next  = krt_pkg::S_IDLE;
            end

            krt_pkg::S_D_RDL:
            begin
                // fetch the last record
                key_raddr  = count_reg[RB-1:0];
                val_raddr  = count_reg[RB-1:0];
                state_next = krt_pkg::S_D_MOV;
            end

            krt_pkg::S_D_MOV:
            begin
                key_we     = 1'b1;
                key_waddr  = slot_reg;
                key_wdata  = key_rdata;
                val_we     = 1'b1;
                val_waddr  = slot_reg;
                val_wdata  = val_rdata;
                pos_next   = krt_pkg::home_of(key_rdata);
                state_next = krt_pkg::S_RP_RD;
            end

            krt_pkg::S_RP_RD:
            begin
                map_raddr  = pos_reg;
                state_next = krt_pkg::S_RP_CHK;
            end

            krt_pkg::S_RP_CHK:
            begin
                if (!map_rd.used || map_rd.slot == count_reg[RB-1:0])
                begin
                    if (map_rd.used)
                    begin
                        map_we    = 1'b1;
                        map_waddr = pos_reg;
                        map_wdata = '{used: 1'b1, slot: slot_reg};
                    end
                    pos_next   = hole_reg + 1'b1;
                    state_next = krt_pkg::S_SH_RD;
                end
                else
                begin
                    pos_next   = step.pos_inc;
                    state_next = krt_pkg::S_RP_RD;
                end
            end

            krt_pkg::S_SH_RD:
            begin
                map_raddr  = pos_reg;
                state_next = krt_pkg::S_SH_CHK;
            end

            krt_pkg::S_SH_CHK:
            begin
                if (!map_rd.used)
                begin
                    map_we      = 1'b1;
                    map_waddr   = hole_reg;
                    map_wdata   = '0;
                    done_next   = 1'b1;
                    status_next = krt_pkg::ST_OK;
                    rdv_next    = '0;
                    state_next  = krt_pkg::S_IDLE;
                end
                else
                begin
                    ent_next   = map_rd;
                    key_raddr  = map_rd.slot;
                    state_next = krt_pkg::S_SH_KEY;
                end
            end

            krt_pkg::S_SH_KEY:
            begin
                if (step.movable)
                begin
                    map_we    = 1'b1;
                    map_waddr = hole_reg;
                    map_wdata = ent_reg;
                    hole_next = pos_reg;
                end
                pos_next   = step.pos_inc;
                state_next = krt_pkg::S_SH_RD;
            end

            default:
            begin
                state_next = krt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/keyed_record_table_linear_probe_test.sv =====
`timescale 1ns / 1ps

// Testbench for the linear-probing keyed record table.
// Commands go through a driver fed from cmd_queue, which also carries
// default_value writes and sync points (wait until the table is idle).
// A behavioral copy of the table runs on every accepted command and
// queues the expected result. The monitor checks each done strobe against it.
module keyed_record_table_linear_probe_test;
    import krt_pkg::*;

    typedef enum logic [1:0] {
        ITEM_CMD,
        ITEM_CFG,
        ITEM_SYNC
    } item_kind_t;

    typedef struct {
        item_kind_t        kind;
        cmd_t              op;
        logic [31:0]       k;
        logic [31:0]       v;
    } table_item_t;

    typedef struct {
        status_t                 st;
        logic [31:0]             rd;
        logic [COUNT_BITS-1:0]   total;
    } table_result_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] cmd = CMD_LOOKUP;
    logic [KEY_WIDTH-1:0] key = '0;
    logic [VALUE_WIDTH-1:0] value = '0;
    logic cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;
    logic busy;
    logic cfg_ready;
    logic done;
    logic [1:0] status;
    logic [31:0] read_value;
    logic [COUNT_BITS-1:0] record_total;

    keyed_record_table_linear_probe i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .key          (key),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .read_value   (read_value),
        .record_total (record_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table model: map entries point into dense key/value stores.
    // ------------------------------------------------------------------
    bit                     map_used [MAP_SIZE];
    logic [RECORD_BITS-1:0] map_slot [MAP_SIZE];
    logic [31:0]            key_mem  [REC_LIMIT];
    logic [31:0]            val_mem  [REC_LIMIT];
    int unsigned            rec_count;
    logic [31:0]            miss_value;

    table_item_t   cmd_queue[$];
    table_result_t pending_results[$];
    int            errors;

    // Returns the map position holding k, or the first free entry of its cluster.
    function automatic logic [MAP_BITS-1:0] find_entry(input logic [31:0] k,
                                                       output bit hit);
        logic [MAP_BITS-1:0] i;
        i = k[MAP_BITS-1:0];
        hit = 1'b0;
        for (int n = 0; n < MAP_SIZE; n++)
        begin
            if (!map_used[i])
                return i;
            if (key_mem[map_slot[i]] == k)
            begin
                hit = 1'b1;
                return i;
            end
            i = i + 1'b1;
        end
        return i;
    endfunction

    // Delete: fill the freed slot with the last record, then close the gap
    // in the probe cluster by shifting later entries back.
    task automatic drop_entry(input logic [MAP_BITS-1:0] pos);
        logic [RECORD_BITS-1:0] slot;
        logic [MAP_BITS-1:0]    hole;
        logic [MAP_BITS-1:0]    j;
        logic [MAP_BITS-1:0]    k;
        logic [MAP_BITS-1:0]    h;
        logic [31:0]            mk;
        bit                     movable;
        slot = map_slot[pos];
        hole = pos;
        j = pos;
        rec_count--;
        if (slot < rec_count)
        begin
            mk = key_mem[rec_count[RECORD_BITS-1:0]];
            key_mem[slot] = mk;
            val_mem[slot] = val_mem[rec_count[RECORD_BITS-1:0]];
            k = mk[MAP_BITS-1:0];
            for (int n = 0; n < MAP_SIZE && map_used[k]; n++)
            begin
                if (map_slot[k] == rec_count[RECORD_BITS-1:0])
                begin
                    map_slot[k] = slot;
                    break;
                end
                k = k + 1'b1;
            end
        end
        for (int n = 0; n < MAP_SIZE; n++)
        begin
            j = j + 1'b1;
            if (!map_used[j])
                break;
            h = key_mem[map_slot[j]][MAP_BITS-1:0];
            if (j > hole)
                movable = (h <= hole) || (h > j);
            else
                movable = (h <= hole) && (h > j);
            if (movable)
            begin
                map_slot[hole] = map_slot[j];
                hole = j;
            end
        end
        map_used[hole] = 1'b0;
        map_slot[hole] = '0;
    endtask

    task automatic table_apply(input cmd_t op, input logic [31:0] k, input logic [31:0] v);
        table_result_t       r;
        logic [MAP_BITS-1:0] pos;
        bit                  hit;
        r.st = ST_MISSING;
        r.rd = '0;
        case (op)
            CMD_LOOKUP:
            begin
                pos = find_entry(k, hit);
                if (hit)
                begin
                    r.st = ST_OK;
                    r.rd = val_mem[map_slot[pos]];
                end
                else
                    r.rd = miss_value;
            end
            CMD_PUT:
            begin
                pos = find_entry(k, hit);
                if (hit)
                begin
                    val_mem[map_slot[pos]] = v;
                    r.st = ST_OK;
                end
                else if (rec_count >= REC_LIMIT)
                    r.st = ST_FULL;
                else
                begin
                    key_mem[rec_count[RECORD_BITS-1:0]] = k;
                    val_mem[rec_count[RECORD_BITS-1:0]] = v;
                    map_used[pos] = 1'b1;
                    map_slot[pos] = rec_count[RECORD_BITS-1:0];
                    rec_count++;
                    r.st = ST_INSERTED;
                end
            end
            CMD_DELETE:
            begin
                pos = find_entry(k, hit);
                if (hit)
                begin
                    drop_entry(pos);
                    r.st = ST_OK;
                end
            end
            default: ;
        endcase
        r.total = rec_count[COUNT_BITS-1:0];
        pending_results.insert(pending_results.size(), r);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of commands with random gaps; cfg writes and sync
    // points wait for an idle table.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;
    int settle = 0;
    int idle_wait = 0;

    always @(posedge clk or negedge rst_n)
    begin
        table_item_t head;
        bit          accepted;
        bit          can_load;
        logic        nstart;
        logic        ncfg;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            cmd <= CMD_LOOKUP;
            key <= '0;
            value <= '0;
            cfg_data <= '0;
        end
        else
        begin
            accepted = start && !busy;
            if (accepted)
                table_apply(cmd_t'(cmd), key, value);
            if (cfg_valid && cfg_ready)
                miss_value = cfg_data;

            if (accepted || cfg_valid || pending_results.size() != 0 || busy)
                settle = 0;
            else
                settle++;

            nstart = start && !accepted;
            ncfg = 1'b0;
            can_load = !start || accepted;
            if (can_load && gap_left > 0)
                gap_left--;
            else if (can_load && cmd_queue.size() != 0)
            begin
                head = cmd_queue[0];
                if (head.kind == ITEM_CMD)
                begin
                    cmd_queue.delete(0);
                    cmd <= head.op;
                    key <= head.k;
                    value <= head.v;
                    nstart = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                               : $urandom_range(0, 6);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
                    end
                end
                else if (!accepted && settle >= SETTLE_CYCLES && !cfg_valid)
                begin
                    cmd_queue.delete(0);
                    if (head.kind == ITEM_CFG)
                    begin
                        cfg_data <= head.v;
                        ncfg = 1'b1;
                    end
                end
            end
            start <= nstart;
            cfg_valid <= ncfg;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results cannot be stalled, check each strobe on arrival.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        table_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d read_value=%h total=%0d",
                         $time, status, read_value, record_total);
            end
            else
            begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                if (status !== exp_r.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
                end
                if (read_value !== exp_r.rd)
                begin
                    errors++;
                    $display("%0t: read_value expected %h actual %h",
                             $time, exp_r.rd, read_value);
                end
                if (record_total !== exp_r.total)
                begin
                    errors++;
                    $display("%0t: record_total expected %0d actual %0d",
                             $time, exp_r.total, record_total);
                end
            end
        end
    end

    // Watchdog: cycles without any transaction (limit covers the map clear after reset).
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_valid)
            idle_wait <= 0;
        else if (idle_wait >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_wait <= idle_wait + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [31:0] key_pool[$];

    task automatic add_cmd(input cmd_t op, input logic [31:0] k, input logic [31:0] v);
        table_item_t it;
        it.kind = ITEM_CMD;
        it.op = op;
        it.k = k;
        it.v = v;
        cmd_queue.insert(cmd_queue.size(), it);
    endtask

    task automatic add_cfg(input logic [31:0] d);
        table_item_t it;
        it.kind = ITEM_CFG;
        it.op = CMD_LOOKUP;
        it.k = '0;
        it.v = d;
        cmd_queue.insert(cmd_queue.size(), it);
    endtask

    task automatic add_sync();
        table_item_t it;
        it.kind = ITEM_SYNC;
        it.op = CMD_LOOKUP;
        it.k = '0;
        it.v = '0;
        cmd_queue.insert(cmd_queue.size(), it);
    endtask

    // Fresh key: random upper bits, home entries bunched so clusters form,
    // some near the top of the map so probing wraps.
    function automatic logic [31:0] fresh_key();
        logic [31:0] k;
        k = $urandom;
        case ($urandom_range(0, 3))
            0, 3: k[MAP_BITS-1:0] = MAP_BITS'($urandom_range(0, 31));
            1:    k[MAP_BITS-1:0] = MAP_BITS'($urandom_range(MAP_SIZE - 16, MAP_SIZE - 1));
            default: ;
        endcase
        if (key_pool.size() < 400)
            key_pool.insert(key_pool.size(), k);
        return k;
    endfunction

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 1) == 1)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return fresh_key();
    endfunction

    task automatic random_phase(input int n, input int put_pct);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < put_pct)
                add_cmd(CMD_PUT, pick_key(), $urandom);
            else if (r < put_pct + (100 - put_pct) / 2)
                add_cmd(CMD_LOOKUP, pick_key(), $urandom);
            else if (r < 96)
                add_cmd(CMD_DELETE, pick_key(), $urandom);
            else
                add_cmd(CMD_NONE, $urandom, $urandom);
        end
    endtask

    initial
    begin
        errors = 0;
        rec_count = 0;
        miss_value = '0;
        for (int i = 0; i < MAP_SIZE; i++)
        begin
            map_used[i] = 1'b0;
            map_slot[i] = '0;
        end

        // Directed: collisions on home 0, wrap at the map top, update,
        // delete with last-record move and cluster shift, absent delete,
        // unused command, default on miss.
        add_cfg(32'hFFFF_FFFF);
        add_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        add_cmd(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        add_cmd(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        add_cmd(CMD_PUT, 32'h0000_0200, 32'h1234_5678);
        add_cmd(CMD_PUT, 32'h0000_01FF, 32'hA5A5_A5A5);
        add_cmd(CMD_PUT, 32'h0000_03FF, 32'h5A5A_5A5A);
        add_cmd(CMD_PUT, 32'h0000_0001, 32'h0000_0001);
        add_cmd(CMD_LOOKUP, 32'h0000_0200, 32'h0);
        add_cmd(CMD_LOOKUP, 32'h0000_03FF, 32'h0);
        add_cmd(CMD_PUT, 32'h0000_0000, 32'h8000_0000);
        add_cmd(CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
        add_cmd(CMD_DELETE, 32'h0000_0000, 32'h0);
        add_cmd(CMD_LOOKUP, 32'h0000_0200, 32'h0);
        add_cmd(CMD_LOOKUP, 32'h0000_0001, 32'h0);
        add_cmd(CMD_DELETE, 32'h0000_0000, 32'h0);
        add_cmd(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        add_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        add_sync();
        add_cfg(32'h0000_0000);
        add_cmd(CMD_LOOKUP, 32'h7FFF_FE00, 32'h0);
        add_cmd(CMD_LOOKUP, 32'h0000_03FF, 32'h0);

        // Random mixed traffic.
        random_phase(250, 40);
        add_sync();
        add_cfg($urandom);
        // Fill to capacity, then put more to hit the full status.
        for (int i = 0; i < REC_LIMIT + 20; i++)
            add_cmd(CMD_PUT, fresh_key(), $urandom);
        random_phase(60, 50);
        add_sync();
        add_cfg(32'hFFFF_FFFF);
        // Drain with deletes heavy, then mixed traffic again.
        random_phase(250, 15);
        add_sync();
        add_cfg($urandom);
        random_phase(250, 40);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || pending_results.size() != 0 || start)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/krt_pkg.sv
rtl/krt_ram.sv
rtl/krt_step.sv
rtl/keyed_record_table_linear_probe.sv
tb/keyed_record_table_linear_probe_test.sv
